// File: hdl/lzrw_pkg.sv
`default_nettype none

package lzrw_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 16;
    localparam int CFG_W = 10;
    localparam int CNT_W = 6;
    localparam int PAIR_HI_W = 7;

    localparam logic [CFG_W-1:0] CFG_START_POS_RESET = 10'd991;

    localparam logic [BYTE_W-1:0] CMD_LITERAL_BASE = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_RLE_BASE = 8'hC0;
    localparam logic [BYTE_W-1:0] CMD_ZERO_BASE = 8'hE0;

    typedef enum logic [3:0] {
        S_LEN_LO,
        S_LEN_HI,
        S_CMD,
        S_PAIR_LO,
        S_LITERAL,
        S_RLE_VAL,
        S_RUN,
        S_COPY
    } state_t;

    typedef enum logic [1:0] {
        KIND_PAIR,
        KIND_LITERAL,
        KIND_RLE,
        KIND_ZERO
    } cmd_kind_t;

    typedef enum logic [2:0] {
        CNT_HOLD,
        CNT_LOW5,
        CNT_LOW5_P1,
        CNT_PAIR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        EMIT_BYTE,
        EMIT_VAL,
        EMIT_RD
    } emit_src_t;

    typedef struct packed {
        logic      start;
        logic      len_hi;
        logic      consume;
        logic      ld_pair_hi;
        cnt_op_t   cnt_op;
        logic      val_ld;
        logic      val_zero;
        logic      ld_copy;
        logic      emit;
        emit_src_t emit_src;
        logic      emit_last;
        logic      emit_end;
        logic      copy_step;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      low5_zero;
        logic      len_empty;
        logic      done_inc;
        logic      done_now;
        logic      cnt_zero;
        logic      cnt_one;
        logic      slot_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// File: hdl/lz_rle_window_decompressor.sv
`default_nettype none

// LZ / run-length / zero-fill decompressor with a history window.
// Input beats on s_valid/s_ready carry one compressed byte each: two length
// bytes (low first), then commands. Output beats on m_valid/m_ready carry one
// decompressed byte with run_last on the last byte an input beat produced and
// stream_end on the last byte of a stream.
// cfg_wr_en/cfg_wr_data write the window start position (taken at the next
// stream start); write only while idle.
// A literal byte shows on the output the cycle after its beat. Zero-fill, run
// and copy commands emit their bytes from the run or copy state that the
// starting beat leads to, through the output register, and no input is taken
// until the last one is emitted. The output register sets the
// rate: one byte per cycle while m_ready is high.
// A stall on m_ready holds the output register and pauses the emitting
// sequence; literal beats are refused until the register is free.
// The window is never swept: a fill count marks what this stream has
// written and everything else reads as zero, so a new stream starts at once.
// Reset: synchronous, aresetn low; output empty, parser waits for a length.

module lz_rle_window_decompressor #(
    parameter int WINDOW_BITS = 10
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire  [lzrw_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [lzrw_pkg::BYTE_W-1:0]  s_in_byte,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [lzrw_pkg::BYTE_W-1:0]  m_out_byte,
    output logic                         m_run_last,
    output logic                         m_stream_end
);
    import lzrw_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t st;

    lzrw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    lzrw_datapath #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_run_last   (m_run_last),
        .m_stream_end (m_stream_end),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

`default_nettype wire

// File: hdl/lzrw_ctrl.sv
`default_nettype none

module lzrw_ctrl (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_valid,
    output logic                       s_ready,
    input  lzrw_pkg::ctrl_status_t     st,
    output lzrw_pkg::ctrl_cmd_t        cmd
);
    import lzrw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LEN_LO;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        cmd.cnt_op = CNT_HOLD;
        cmd.emit_src = EMIT_BYTE;
        s_ready = 1'b0;
        accept = 1'b0;
        unique case (state_reg)
            S_LEN_LO: begin
                s_ready = 1'b1;
                accept = s_valid;
                if (accept) begin
                    cmd.start = 1'b1;
                    state_next = S_LEN_HI;
                end
            end
            S_LEN_HI: begin
                s_ready = 1'b1;
                accept = s_valid;
                if (accept) begin
                    cmd.len_hi = 1'b1;
                    state_next = st.len_empty ? S_LEN_LO : S_CMD;
                end
            end
            S_CMD: begin
                s_ready = 1'b1;
                accept = s_valid;
                if (accept) begin
                    cmd.consume = 1'b1;
                    unique case (st.kind)
                        KIND_PAIR: begin
                            cmd.ld_pair_hi = 1'b1;
                            state_next = S_PAIR_LO;
                        end
                        KIND_LITERAL: begin
                            cmd.cnt_op = CNT_LOW5;
                            if (st.low5_zero) begin
                                state_next = st.done_inc ? S_LEN_LO : S_CMD;
                            end else begin
                                state_next = S_LITERAL;
                            end
                        end
                        KIND_RLE: begin
                            cmd.cnt_op = CNT_LOW5;
                            state_next = S_RLE_VAL;
                        end
                        KIND_ZERO: begin
                            cmd.cnt_op = CNT_LOW5_P1;
                            cmd.val_ld = 1'b1;
                            cmd.val_zero = 1'b1;
                            state_next = S_RUN;
                        end
                        default: begin
                            state_next = S_CMD;
                        end
                    endcase
                end
            end
            S_PAIR_LO: begin
                s_ready = 1'b1;
                accept = s_valid;
                if (accept) begin
                    cmd.consume = 1'b1;
                    cmd.cnt_op = CNT_PAIR;
                    cmd.ld_copy = 1'b1;
                    state_next = S_COPY;
                end
            end
            S_LITERAL: begin
                s_ready = st.slot_free;
                accept = s_valid && st.slot_free;
                if (accept) begin
                    cmd.consume = 1'b1;
                    cmd.emit = 1'b1;
                    cmd.emit_src = EMIT_BYTE;
                    cmd.emit_last = 1'b1;
                    cmd.emit_end = st.cnt_one && st.done_inc;
                    cmd.cnt_op = CNT_DEC;
                    if (st.cnt_one) begin
                        state_next = st.done_inc ? S_LEN_LO : S_CMD;
                    end
                end
            end
            S_RLE_VAL: begin
                s_ready = 1'b1;
                accept = s_valid;
                if (accept) begin
                    cmd.consume = 1'b1;
                    cmd.cnt_op = CNT_INC;
                    cmd.val_ld = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (st.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_src = EMIT_VAL;
                    cmd.emit_last = st.cnt_zero;
                    cmd.emit_end = st.cnt_zero && st.done_now;
                    cmd.cnt_op = CNT_DEC;
                    if (st.cnt_zero) begin
                        state_next = st.done_now ? S_LEN_LO : S_CMD;
                    end
                end
            end
            S_COPY: begin
                if (st.slot_free) begin
                    cmd.emit = 1'b1;
                    cmd.emit_src = EMIT_RD;
                    cmd.copy_step = 1'b1;
                    cmd.emit_last = st.cnt_zero;
                    cmd.emit_end = st.cnt_zero && st.done_now;
                    cmd.cnt_op = CNT_DEC;
                    if (st.cnt_zero) begin
                        state_next = st.done_now ? S_LEN_LO : S_CMD;
                    end
                end
            end
            default: begin
                state_next = S_LEN_LO;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/lzrw_datapath.sv
`default_nettype none

module lzrw_datapath #(
    parameter int WINDOW_BITS = 10
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_wr_en,
    input  wire  [lzrw_pkg::CFG_W-1:0]    cfg_wr_data,
    input  wire  [lzrw_pkg::BYTE_W-1:0]   s_in_byte,
    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [lzrw_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                          m_run_last,
    output logic                          m_stream_end,
    input  lzrw_pkg::ctrl_cmd_t           cmd,
    output lzrw_pkg::ctrl_status_t        st
);
    import lzrw_pkg::*;

    localparam int W = WINDOW_BITS;
    localparam int FW = WINDOW_BITS + 1;
    localparam int WSIZE = 1 << WINDOW_BITS;
    localparam logic [FW-1:0] FILL_FULL = FW'(WSIZE);

    logic [BYTE_W-1:0]    window_mem [WSIZE];

    logic [CFG_W-1:0]     cfg_reg;
    logic                 m_valid_reg;
    logic [FW-1:0]        fill_reg;

    logic [BYTE_W-1:0]    len_lo_reg;
    logic [BYTE_W-1:0]    len_hi_reg;
    logic [LEN_W-1:0]     consumed_reg;
    logic [PAIR_HI_W-1:0] pair_hi_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [BYTE_W-1:0]    val_reg;
    logic [W-1:0]         start_pos_reg;
    logic [W-1:0]         write_pos_reg;
    logic [W-1:0]         copy_pos_reg;
    logic [BYTE_W-1:0]    mem_q_reg;
    logic [BYTE_W-1:0]    byp_data_reg;
    logic                 byp_reg;
    logic                 hit_reg;
    logic [BYTE_W-1:0]    out_byte_reg;
    logic                 run_last_reg;
    logic                 stream_end_reg;

    logic [LEN_W-1:0]     length;
    logic [LEN_W-1:0]     consumed_inc;
    logic [W-1:0]         start_pos;
    logic [W-1:0]         rd_addr;
    logic [W-1:0]         rd_off;
    logic                 rd_en;
    logic                 bypass;
    logic                 rd_hit;
    logic [BYTE_W-1:0]    rd_data;
    logic [BYTE_W-1:0]    emit_data;

    always_comb begin
        length = {len_hi_reg, len_lo_reg};
        consumed_inc = (consumed_reg == '1) ? consumed_reg : consumed_reg + 1'b1;
        start_pos = W'(cfg_reg);

        if (s_in_byte < CMD_LITERAL_BASE) begin
            st.kind = KIND_PAIR;
        end else if (s_in_byte < CMD_RLE_BASE) begin
            st.kind = KIND_LITERAL;
        end else if (s_in_byte < CMD_ZERO_BASE) begin
            st.kind = KIND_RLE;
        end else begin
            st.kind = KIND_ZERO;
        end
        st.low5_zero = (s_in_byte[4:0] == '0);
        st.len_empty = (s_in_byte == '0) && (len_lo_reg == '0);
        st.done_inc = (consumed_inc >= length);
        st.done_now = (consumed_reg >= length);
        st.cnt_zero = (cnt_reg == '0);
        st.cnt_one = (cnt_reg == CNT_W'(1));
        st.slot_free = !m_valid_reg || m_ready;

        rd_data = !hit_reg ? '0 : (byp_reg ? byp_data_reg : mem_q_reg);

        case (cmd.emit_src)
            EMIT_BYTE: emit_data = s_in_byte;
            EMIT_VAL:  emit_data = val_reg;
            EMIT_RD:   emit_data = rd_data;
            default:   emit_data = s_in_byte;
        endcase

        rd_en = cmd.ld_copy || (cmd.emit && cmd.copy_step);
        rd_addr = cmd.ld_copy ? W'({pair_hi_reg, s_in_byte}) : copy_pos_reg + 1'b1;
        bypass = cmd.emit && (write_pos_reg == rd_addr);
        rd_off = rd_addr - start_pos_reg;
        rd_hit = ({1'b0, rd_off} < fill_reg) || bypass;

        case (cmd.cnt_op)
            CNT_LOW5:    cnt_next = {1'b0, s_in_byte[4:0]};
            CNT_LOW5_P1: cnt_next = {1'b0, s_in_byte[4:0]} + 1'b1;
            CNT_PAIR:    cnt_next = {1'b0, pair_hi_reg[6:2]} + 1'b1;
            CNT_INC:     cnt_next = cnt_reg + 1'b1;
            CNT_DEC:     cnt_next = cnt_reg - 1'b1;
            default:     cnt_next = cnt_reg;
        endcase
    end

    // window: old data on read, same-cycle write handled by the bypass
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            window_mem[write_pos_reg] <= emit_data;
        end
        if (rd_en) begin
            mem_q_reg <= window_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_START_POS_RESET;
            m_valid_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                cfg_reg <= cfg_wr_data;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.start) begin
                fill_reg <= '0;
            end else if (cmd.emit && (fill_reg != FILL_FULL)) begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            len_lo_reg <= s_in_byte;
            consumed_reg <= '0;
            start_pos_reg <= start_pos;
        end else if (cmd.consume) begin
            consumed_reg <= consumed_inc;
        end
        if (cmd.len_hi) begin
            len_hi_reg <= s_in_byte;
        end
        if (cmd.ld_pair_hi) begin
            pair_hi_reg <= s_in_byte[PAIR_HI_W-1:0];
        end
        cnt_reg <= cnt_next;
        if (cmd.val_ld) begin
            val_reg <= cmd.val_zero ? '0 : s_in_byte;
        end
        if (cmd.start) begin
            write_pos_reg <= start_pos;
        end else if (cmd.emit) begin
            write_pos_reg <= write_pos_reg + 1'b1;
        end
        if (rd_en) begin
            copy_pos_reg <= rd_addr;
            byp_reg <= bypass;
            byp_data_reg <= emit_data;
            hit_reg <= rd_hit;
        end
        if (cmd.emit) begin
            out_byte_reg <= emit_data;
            run_last_reg <= cmd.emit_last;
            stream_end_reg <= cmd.emit_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_out_byte = out_byte_reg;
    assign m_run_last = run_last_reg;
    assign m_stream_end = stream_end_reg;

endmodule

`default_nettype wire

// File: hdl/lzrw_checker.sv
`default_nettype none

module lzrw_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_valid,
    input wire       s_ready,
    input wire       m_valid,
    input wire       m_ready,
    input wire [7:0] m_out_byte,
    input wire       m_run_last,
    input wire       m_stream_end
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
            && $stable(m_run_last) && $stable(m_stream_end))
        else $error("output beat changed while stalled");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_stream_end |-> m_run_last)
        else $error("stream end without run last");

    // mid-run bytes pending means the sequencer still owns the input side
    a_no_input_mid_run: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |-> !s_ready)
        else $error("input taken while a run is unfinished");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output not empty after reset");

endmodule

bind lz_rle_window_decompressor lzrw_checker u_lzrw_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_byte   (m_out_byte),
    .m_run_last   (m_run_last),
    .m_stream_end (m_stream_end)
);

`default_nettype wire
